// File: rtl/fpalu_pkg.sv
// Package for the fixed-point ALU: operation codes, widths, defaults.
// No dependencies.
`timescale 1ns / 1ps
package fpalu_pkg;
  localparam int DataWidth = 32;
  localparam int FractionBitsDefault = 8;
  typedef enum logic [3:0] {
    CMD_ADD = 4'd0, CMD_SUB = 4'd1, CMD_MUL = 4'd2, CMD_DIV = 4'd3,
    CMD_GT = 4'd4, CMD_LT = 4'd5, CMD_GE = 4'd6, CMD_LE = 4'd7,
    CMD_EQ = 4'd8, CMD_NE = 4'd9, CMD_MIN = 4'd10, CMD_MAX = 4'd11,
    CMD_INC = 4'd12, CMD_DEC = 4'd13, CMD_FROM_INT = 4'd14, CMD_TO_INT = 4'd15
  } cmd_t;
endpackage

// File: rtl/fpalu_mul.sv
// Pipelined multiplier: 16-bit partial products, shift, truncate, saturate.
// Depends on fpalu_pkg. Advances on en; partial products, sum and result are registered in turn.
`timescale 1ns / 1ps
module fpalu_mul #(
  parameter int FRACTION_BITS = fpalu_pkg::FractionBitsDefault
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic [31:0]        res,
  output logic               ovf
);
  logic [31:0] ma, mb;
  logic        neg1, neg2;
  logic [31:0] pll, plh, phl, phh;
  logic [63:0] mag;
  logic [63:0] q;
  assign ma = a[31] ? 32'(-a) : a;
  assign mb = b[31] ? 32'(-b) : b;
  assign q = mag >> FRACTION_BITS;
  always_ff @(posedge clk) begin
    if (en) begin
      pll  <= 32'(ma[15:0]) * 32'(mb[15:0]);
      plh  <= 32'(ma[15:0]) * 32'(mb[31:16]);
      phl  <= 32'(ma[31:16]) * 32'(mb[15:0]);
      phh  <= 32'(ma[31:16]) * 32'(mb[31:16]);
      neg1 <= a[31] ^ b[31];
      mag  <= {phh, pll} + {16'd0, plh, 16'd0} + {16'd0, phl, 16'd0};
      neg2 <= neg1;
      if (!neg2) begin
        ovf <= |q[63:31];
        res <= (|q[63:31]) ? 32'h7fffffff : q[31:0];
      end else begin
        ovf <= (q > 64'h80000000);
        res <= (q > 64'h80000000) ? 32'h80000000 : 32'(-q[31:0]);
      end
    end
  end
endmodule

// File: rtl/fpalu_div.sv
// Pipelined restoring divider, one quotient bit per stage, then saturation.
// Depends on fpalu_pkg. Advances on en; input, quotient-bit stages and saturated result are registered in turn.
`timescale 1ns / 1ps
module fpalu_div #(
  parameter int FRACTION_BITS = fpalu_pkg::FractionBitsDefault
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic [31:0]        res,
  output logic               ovf
);
  localparam int QW = 32 + FRACTION_BITS;
  logic [QW-1:0] num [QW+1];
  logic [32:0]   rem [QW+1];
  logic [31:0]   den [QW+1];
  logic          neg [QW+1];
  logic [33:0]   trial [QW];
  logic [31:0]   ma, mb;
  assign ma = a[31] ? 32'(-a) : a;
  assign mb = b[31] ? 32'(-b) : b;
  always_ff @(posedge clk) begin
    if (en) begin
      num[0] <= {ma, FRACTION_BITS'(0)};
      rem[0] <= '0;
      den[0] <= mb;
      neg[0] <= a[31] ^ b[31];
    end
  end
  for (genvar i = 0; i < QW; i++) begin : g_st
    assign trial[i] = {rem[i], num[i][QW-1]} - {2'b00, den[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        den[i+1] <= den[i];
        neg[i+1] <= neg[i];
        if (!trial[i][33]) begin
          rem[i+1] <= trial[i][32:0];
          num[i+1] <= {num[i][QW-2:0], 1'b1};
        end else begin
          rem[i+1] <= {rem[i][31:0], num[i][QW-1]};
          num[i+1] <= {num[i][QW-2:0], 1'b0};
        end
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (!neg[QW]) begin
        ovf <= |num[QW][QW-1:31];
        res <= (|num[QW][QW-1:31]) ? 32'h7fffffff : num[QW][31:0];
      end else begin
        ovf <= (num[QW] > QW'(33'h80000000));
        res <= (num[QW] > QW'(33'h80000000)) ? 32'h80000000 : 32'(-num[QW][31:0]);
      end
    end
  end
endmodule

// File: rtl/fixed_point_alu.sv
// Fixed-point ALU top level: handshake, simple ops, mul and div pipelines.
// Depends on fpalu_pkg, fpalu_mul, fpalu_div.
// All items share one pipeline whose depth matches the divider's whole register chain.
// Throughput one item per cycle; whole pipe freezes while output stalls.
// Synchronous reset clears the valid bits only.
`timescale 1ns / 1ps
module fixed_point_alu #(
  parameter int FRACTION_BITS = fpalu_pkg::FractionBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         cmd,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] result_value,
  output logic               compare_true,
  output logic               divide_by_zero,
  output logic               overflow
);
  localparam int LAT = 32 + FRACTION_BITS + 2;
  typedef struct packed {
    logic [3:0]  cmd;
    logic [31:0] res;
    logic        cmp;
    logic        dz;
  } simple_t;
  logic    en;
  logic    vld  [LAT];
  simple_t pipe [LAT];
  simple_t s;
  logic [31:0] mres, dres, fin;
  logic        movf, dovf, fovf;
  logic        lt, eq;
  fpalu_pkg::cmd_t c;

  assign en = !(out_valid && out_stall);
  assign in_stall = !en;
  assign c = fpalu_pkg::cmd_t'(cmd);
  assign lt = operand_a < operand_b;
  assign eq = operand_a == operand_b;

  always_comb begin
    s = '{cmd: cmd, res: 32'd0, cmp: 1'b0, dz: 1'b0};
    unique case (c)
      fpalu_pkg::CMD_ADD: s.res = operand_a + operand_b;
      fpalu_pkg::CMD_SUB: s.res = operand_a - operand_b;
      fpalu_pkg::CMD_MUL: s.res = '0;
      fpalu_pkg::CMD_DIV: begin
        s.dz = operand_b == 0;
        s.res = operand_a;
      end
      fpalu_pkg::CMD_GT: s.cmp = !lt && !eq;
      fpalu_pkg::CMD_LT: s.cmp = lt;
      fpalu_pkg::CMD_GE: s.cmp = !lt;
      fpalu_pkg::CMD_LE: s.cmp = lt || eq;
      fpalu_pkg::CMD_EQ: s.cmp = eq;
      fpalu_pkg::CMD_NE: s.cmp = !eq;
      fpalu_pkg::CMD_MIN: s.res = lt ? operand_a : operand_b;
      fpalu_pkg::CMD_MAX: s.res = (!lt && !eq) ? operand_a : operand_b;
      fpalu_pkg::CMD_INC: s.res = operand_a + 32'd1;
      fpalu_pkg::CMD_DEC: s.res = operand_a - 32'd1;
      fpalu_pkg::CMD_FROM_INT: s.res = operand_a << FRACTION_BITS;
      fpalu_pkg::CMD_TO_INT: s.res = operand_a >>> FRACTION_BITS;
      default: s.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 1; i < LAT; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0] <= s;
      for (int i = 1; i < LAT; i++) pipe[i] <= pipe[i-1];
    end
  end

  fpalu_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
    .clk(clk), .en(en), .a(operand_a), .b(operand_b), .res(mres), .ovf(movf)
  );

  // Multiplier result is delayed to line up with the divider.
  logic [32:0] mdly [LAT-3];
  always_ff @(posedge clk) begin
    if (en) begin
      mdly[0] <= {movf, mres};
      for (int i = 1; i < LAT - 3; i++) mdly[i] <= mdly[i-1];
    end
  end

  fpalu_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk(clk), .en(en), .a(operand_a), .b(operand_b), .res(dres), .ovf(dovf)
  );

  always_comb begin
    fin  = pipe[LAT-1].res;
    fovf = 1'b0;
    if (pipe[LAT-1].cmd == fpalu_pkg::CMD_MUL) begin
      fin  = mdly[LAT-4][31:0];
      fovf = mdly[LAT-4][32];
    end else if (pipe[LAT-1].cmd == fpalu_pkg::CMD_DIV && !pipe[LAT-1].dz) begin
      fin  = dres;
      fovf = dovf;
    end
  end

  assign out_valid      = vld[LAT-1];
  assign result_value   = fin;
  assign compare_true   = pipe[LAT-1].cmp;
  assign divide_by_zero = pipe[LAT-1].dz;
  assign overflow       = fovf;
endmodule
